// ----- src/mwsc_pkg.sv -----
// Package for the mecanum wheel speed controller: constants, types and helper functions.
package mwsc_pkg;

  localparam int PWM_TOP     = 16799;
  localparam int DRIVE_LIMIT = 16700;
  localparam int FRAC_BITS   = 12;
  localparam int GEOM_BITS   = 16;

  localparam int VEL_W  = 16;
  localparam int GAIN_W = 16;
  localparam int LIM_W  = 15;
  localparam int CMP_W  = 15;
  localparam int TGT_W  = 16;
  localparam int ERR_W  = 18;
  localparam int DIF_W  = 19;
  localparam int ACC_W  = 28;
  localparam int DRV_W  = ACC_W - FRAC_BITS;
  localparam int MA_W   = GAIN_W + 1;
  localparam int MP_W   = MA_W + DIF_W;
  localparam int SUM_W  = MP_W + 1;
  localparam int KIN_W  = 19;
  localparam int ROT_W  = VEL_W + 1;
  localparam int NWHEEL = 4;

  localparam logic signed [SUM_W-1:0] SAT_VAL =
    SUM_W'(longint'(DRIVE_LIMIT) <<< FRAC_BITS);

  localparam int IDX_W = 3;
  localparam logic [IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [IDX_W-1:0] REG_INT_GAIN_A = 3'd1;
  localparam logic [IDX_W-1:0] REG_INT_GAIN_B = 3'd2;
  localparam logic [IDX_W-1:0] REG_INT_GAIN_C = 3'd3;
  localparam logic [IDX_W-1:0] REG_INT_GAIN_D = 3'd4;
  localparam logic [IDX_W-1:0] REG_GEOMETRY   = 3'd5;
  localparam logic [IDX_W-1:0] REG_SPEED_LIM  = 3'd6;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_ROT  = 8'b0000_0010,
    S_KIN  = 8'b0000_0100,
    S_ERR  = 8'b0000_1000,
    S_PMUL = 8'b0001_0000,
    S_IMUL = 8'b0010_0000,
    S_ACC  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic [CMP_W-1:0] first;
    logic [CMP_W-1:0] second;
  } cmp_pair_t;

  // truncate toward zero to whole counts
  function automatic logic signed [DRV_W-1:0] drive_of(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] t;
    t = acc + (acc[ACC_W-1] ? ACC_W'((1 << FRAC_BITS) - 1) : '0);
    return t[ACC_W-1:FRAC_BITS];
  endfunction

  // H-bridge split, optionally on the inverted drive
  function automatic cmp_pair_t split(input logic signed [DRV_W-1:0] drv, input logic inv);
    logic signed [DRV_W+1:0] m;
    logic signed [DRV_W+1:0] a;
    logic signed [DRV_W+1:0] b;
    cmp_pair_t r;
    m = inv ? -(DRV_W+2)'(drv) : (DRV_W+2)'(drv);
    if (m < 0) begin
      a = (DRV_W+2)'(PWM_TOP);
      b = (DRV_W+2)'(PWM_TOP) + m;
    end else begin
      a = (DRV_W+2)'(PWM_TOP) - m;
      b = (DRV_W+2)'(PWM_TOP);
    end
    if (a < 0) a = '0;
    if (b < 0) b = '0;
    r.first  = a[CMP_W-1:0];
    r.second = b[CMP_W-1:0];
    return r;
  endfunction

endpackage

// ----- src/mecanum_wheel_speed_controller_unit.sv -----
// Top level: mecanum inverse kinematics and four incremental PI loops on one shared multiplier.
// A beat taken while power is not good skips the loops and goes straight to the done state.
// A new beat is taken only in the idle state, once the last one is through the sequencer; the single
//   multiplier does nine products per tick (one for yaw, two per wheel) under that sequencer.
// A finished result waits in the output register while the next beat is taken.
// Reset (synchronous, rst_n low): registers to their defaults, accumulators and previous errors to zero.
module mecanum_wheel_speed_controller_unit (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  logic [mwsc_pkg::IDX_W-1:0]              cfg_index,
  input  logic [mwsc_pkg::GAIN_W-1:0]             cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [mwsc_pkg::VEL_W-1:0]       in_vel_x,
  input  logic signed [mwsc_pkg::VEL_W-1:0]       in_vel_y,
  input  logic signed [mwsc_pkg::VEL_W-1:0]       in_vel_z,
  input  logic signed [mwsc_pkg::VEL_W-1:0]       in_meas_a,
  input  logic signed [mwsc_pkg::VEL_W-1:0]       in_meas_b,
  input  logic signed [mwsc_pkg::VEL_W-1:0]       in_meas_c,
  input  logic signed [mwsc_pkg::VEL_W-1:0]       in_meas_d,
  input  logic                                    in_move_enable,
  input  logic                                    in_power_ok,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [mwsc_pkg::CMP_W-1:0]              out_cmp_a1,
  output logic [mwsc_pkg::CMP_W-1:0]              out_cmp_a2,
  output logic [mwsc_pkg::CMP_W-1:0]              out_cmp_b1,
  output logic [mwsc_pkg::CMP_W-1:0]              out_cmp_b2,
  output logic [mwsc_pkg::CMP_W-1:0]              out_cmp_c1,
  output logic [mwsc_pkg::CMP_W-1:0]              out_cmp_c2,
  output logic [mwsc_pkg::CMP_W-1:0]              out_cmp_d1,
  output logic [mwsc_pkg::CMP_W-1:0]              out_cmp_d2
);
  import mwsc_pkg::*;

  state_t state_r, state_nxt;

  logic [GAIN_W-1:0] prop_gain_r;
  logic [GAIN_W-1:0] int_gain_r [NWHEEL];
  logic [GAIN_W-1:0] geom_r;
  logic [LIM_W-1:0]  lim_r;

  logic signed [VEL_W-1:0] vx_r, vy_r, vz_r;
  logic signed [VEL_W-1:0] meas_r [NWHEEL];
  logic                    move_r, pwr_r;

  logic signed [TGT_W-1:0] tgt_r   [NWHEEL];
  logic signed [ERR_W-1:0] err_r   [NWHEEL];
  logic signed [ERR_W-1:0] prev_r  [NWHEEL];
  logic signed [ACC_W-1:0] accum_r [NWHEEL];

  logic [1:0]              wheel_r;
  logic signed [MP_W-1:0]  prod_r;
  logic signed [SUM_W-1:0] inc_r;
  logic                    out_valid_r;
  logic [CMP_W-1:0]        cmp_r [2*NWHEEL];

  logic signed [MA_W-1:0]  mul_a;
  logic signed [DIF_W-1:0] mul_b;
  logic signed [MP_W-1:0]  mul_p;

  logic signed [MP_W-1:0]  rnd;
  logic signed [ROT_W-1:0] rot;
  logic signed [KIN_W-1:0] kin [NWHEEL];
  logic signed [KIN_W-1:0] lim_s;
  logic signed [SUM_W-1:0] acc_sum, acc_sat;
  logic                    in_acc, out_free;
  cmp_pair_t               pair [NWHEEL];

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_ROT: begin
        mul_a = MA_W'({1'b0, geom_r});
        mul_b = DIF_W'(vz_r);
      end
      S_PMUL: begin
        mul_a = MA_W'({1'b0, prop_gain_r});
        mul_b = DIF_W'(err_r[wheel_r]) - DIF_W'(prev_r[wheel_r]);
      end
      S_IMUL: begin
        mul_a = MA_W'({1'b0, int_gain_r[wheel_r]});
        mul_b = DIF_W'(err_r[wheel_r]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // kinematics from the registered yaw product
  always_comb begin
    rnd   = prod_r + (MP_W'(1) <<< (GEOM_BITS - 1));
    rot   = rnd[GEOM_BITS+ROT_W-1:GEOM_BITS];
    lim_s = KIN_W'({1'b0, lim_r});
    kin[0] = KIN_W'(vx_r) + KIN_W'(vy_r) - KIN_W'(rot);
    kin[1] = KIN_W'(vx_r) - KIN_W'(vy_r) - KIN_W'(rot);
    kin[2] = KIN_W'(vx_r) + KIN_W'(vy_r) + KIN_W'(rot);
    kin[3] = KIN_W'(vx_r) - KIN_W'(vy_r) + KIN_W'(rot);
    for (int i = 0; i < NWHEEL; i++) begin
      if (kin[i] > lim_s)       kin[i] = lim_s;
      else if (kin[i] < -lim_s) kin[i] = -lim_s;
      if (!move_r)              kin[i] = '0;
    end
  end

  always_comb begin
    acc_sum = inc_r + SUM_W'(prod_r);
    if (acc_sum > SAT_VAL)       acc_sat = SAT_VAL;
    else if (acc_sum < -SAT_VAL) acc_sat = -SAT_VAL;
    else                         acc_sat = acc_sum;
  end

  always_comb begin
    pair[0] = split(drive_of(accum_r[0]), 1'b0);
    pair[1] = split(drive_of(accum_r[1]), 1'b1);
    pair[2] = split(drive_of(accum_r[2]), 1'b1);
    pair[3] = split(drive_of(accum_r[3]), 1'b0);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = in_power_ok ? S_ROT : S_DONE;
      S_ROT:   state_nxt = S_KIN;
      S_KIN:   state_nxt = S_ERR;
      S_ERR:   state_nxt = S_PMUL;
      S_PMUL:  state_nxt = S_IMUL;
      S_IMUL:  state_nxt = S_ACC;
      S_ACC:   state_nxt = (wheel_r == 2'(NWHEEL - 1)) ? S_DONE : S_PMUL;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      wheel_r       <= '0;
      prop_gain_r   <= GAIN_W'(300);
      int_gain_r[0] <= GAIN_W'(1800);
      int_gain_r[1] <= GAIN_W'(1600);
      int_gain_r[2] <= GAIN_W'(1500);
      int_gain_r[3] <= GAIN_W'(300);
      geom_r        <= GAIN_W'(26214);
      lim_r         <= LIM_W'(14336);
      for (int i = 0; i < NWHEEL; i++) begin
        accum_r[i] <= '0;
        prev_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          REG_PROP_GAIN:  prop_gain_r   <= cfg_data;
          REG_INT_GAIN_A: int_gain_r[0] <= cfg_data;
          REG_INT_GAIN_B: int_gain_r[1] <= cfg_data;
          REG_INT_GAIN_C: int_gain_r[2] <= cfg_data;
          REG_INT_GAIN_D: int_gain_r[3] <= cfg_data;
          REG_GEOMETRY:   geom_r        <= cfg_data;
          REG_SPEED_LIM:  lim_r         <= cfg_data[LIM_W-1:0];
          default: ;
        endcase
      end

      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_ready)                out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          wheel_r <= '0;
        end
        S_ACC: begin
          accum_r[wheel_r] <= acc_sat[ACC_W-1:0];
          prev_r[wheel_r]  <= err_r[wheel_r];
          wheel_r          <= wheel_r + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      vx_r      <= in_vel_x;
      vy_r      <= in_vel_y;
      vz_r      <= in_vel_z;
      meas_r[0] <= in_meas_a;
      meas_r[1] <= in_meas_b;
      meas_r[2] <= in_meas_c;
      meas_r[3] <= in_meas_d;
      move_r    <= in_move_enable;
      pwr_r     <= in_power_ok;
    end
    if (state_r == S_ROT || state_r == S_PMUL || state_r == S_IMUL) prod_r <= mul_p;
    if (state_r == S_IMUL) inc_r <= SUM_W'(accum_r[wheel_r]) + SUM_W'(prod_r);
    if (state_r == S_KIN) begin
      for (int i = 0; i < NWHEEL; i++) tgt_r[i] <= kin[i][TGT_W-1:0];
    end
    if (state_r == S_ERR) begin
      for (int i = 0; i < NWHEEL; i++) err_r[i] <= ERR_W'(tgt_r[i]) - ERR_W'(meas_r[i]);
    end
    if (state_r == S_DONE && out_free) begin
      for (int i = 0; i < NWHEEL; i++) begin
        cmp_r[2*i]   <= pwr_r ? pair[i].first  : CMP_W'(PWM_TOP);
        cmp_r[2*i+1] <= pwr_r ? pair[i].second : CMP_W'(PWM_TOP);
      end
    end
  end

  assign out_cmp_a1 = cmp_r[0];
  assign out_cmp_a2 = cmp_r[1];
  assign out_cmp_b1 = cmp_r[2];
  assign out_cmp_b2 = cmp_r[3];
  assign out_cmp_c1 = cmp_r[4];
  assign out_cmp_c2 = cmp_r[5];
  assign out_cmp_d1 = cmp_r[6];
  assign out_cmp_d2 = cmp_r[7];

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_cmp_a1) && $stable(out_cmp_d2))
    else $error("result dropped while stalled");

  a_power_skip: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_power_ok |=> state_r == S_DONE)
    else $error("power-fail beat ran the loops");

  a_power_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_power_ok |=> state_r == S_ROT)
    else $error("beat did not start the sequence");

  a_accum_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ACC |=> SUM_W'(accum_r[$past(wheel_r)]) <= SAT_VAL
                     && SUM_W'(accum_r[$past(wheel_r)]) >= -SAT_VAL)
    else $error("accumulator beyond drive limit");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE && !in_acc |=> $stable(accum_r[0]) && $stable(prev_r[3]))
    else $error("loop state changed while idle");

endmodule

// ----- verif/tb.sv -----
// Testbench for the mecanum wheel speed controller: directed table, random ticks, PI predictor.
`timescale 1ns / 1ps

module tb;
  import mwsc_pkg::*;

  localparam int STUCK_LIMIT = 3000;
  localparam int HOLD_LEN    = 400;

  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam logic [GAIN_W-1:0] KP_RST   = 16'd300;
  localparam logic [GAIN_W-1:0] KA_RST   = 16'd1800;
  localparam logic [GAIN_W-1:0] KB_RST   = 16'd1600;
  localparam logic [GAIN_W-1:0] KC_RST   = 16'd1500;
  localparam logic [GAIN_W-1:0] KD_RST   = 16'd300;
  localparam logic [GAIN_W-1:0] GEOM_RST = 16'd26214;
  localparam logic [GAIN_W-1:0] VLIM_RST = 16'd14336;

  localparam logic signed [VEL_W-1:0] VMAX = 16'sh7fff;
  localparam logic signed [VEL_W-1:0] VMIN = 16'sh8000;
  localparam logic signed [VEL_W-1:0] ONE  = 16'sd4096;

  typedef struct packed {
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic signed [VEL_W-1:0] vz;
    logic signed [VEL_W-1:0] ma;
    logic signed [VEL_W-1:0] mb;
    logic signed [VEL_W-1:0] mc;
    logic signed [VEL_W-1:0] md;
    logic                    move_en;
    logic                    pwr_ok;
  } tick_beat_t;

  // at_top: every compare value is PWM_TOP
  typedef struct packed {
    tick_beat_t beat;
    logic       at_top;
  } dir_row_t;

  // [0] = cmp_a1 ... [7] = cmp_d2
  typedef logic [7:0][CMP_W-1:0] cmp_vec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                    cfg_we = 1'b0;
  logic [IDX_W-1:0]        cfg_index = '0;
  logic [GAIN_W-1:0]       cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [VEL_W-1:0] in_vel_x = '0;
  logic signed [VEL_W-1:0] in_vel_y = '0;
  logic signed [VEL_W-1:0] in_vel_z = '0;
  logic signed [VEL_W-1:0] in_meas_a = '0;
  logic signed [VEL_W-1:0] in_meas_b = '0;
  logic signed [VEL_W-1:0] in_meas_c = '0;
  logic signed [VEL_W-1:0] in_meas_d = '0;
  logic                    in_move_enable = 1'b0;
  logic                    in_power_ok = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [CMP_W-1:0]        out_cmp_a1, out_cmp_a2, out_cmp_b1, out_cmp_b2;
  logic [CMP_W-1:0]        out_cmp_c1, out_cmp_c2, out_cmp_d1, out_cmp_d2;

  // predictor copy of registers and loop state
  logic [GAIN_W-1:0]       kp = KP_RST;
  logic [GAIN_W-1:0]       ki [4] = '{KA_RST, KB_RST, KC_RST, KD_RST};
  logic [GAIN_W-1:0]       geom = GEOM_RST;
  logic [LIM_W-1:0]        vlim = VLIM_RST[LIM_W-1:0];
  logic signed [ACC_W-1:0] drive_acc [4] = '{default: '0};
  logic signed [ERR_W-1:0] prev_err [4] = '{default: '0};

  cmp_vec_t pending_cmp [$];
  cmp_vec_t seen_cmp, want_cmp;
  int       bad_cnt = 0;
  int       stuck_cyc = 0;
  int       snd_idle_pct = 0;
  int       rcv_stall_pct = 0;
  logic     hold_tog = 1'b0;
  logic     hold_seen = 1'b0;
  int       hold_left = 0;

  string fld_name [8] = '{"cmp_a1", "cmp_a2", "cmp_b1", "cmp_b2",
                          "cmp_c1", "cmp_c2", "cmp_d1", "cmp_d2"};

  // vx vy vz ma mb mc md move power | at_top
  dir_row_t dir_rows [20] = '{
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1}, 1'b1},
    '{'{VMAX, VMAX, VMAX, VMIN, VMIN, VMIN, VMIN, 1'b1, 1'b0}, 1'b1},
    '{'{VMIN, VMIN, VMIN, VMAX, VMAX, VMAX, VMAX, 1'b0, 1'b0}, 1'b1},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1}, 1'b1},
    '{'{VMAX, VMAX, VMAX, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1}, 1'b0},
    '{'{VMIN, VMIN, VMIN, VMAX, VMAX, VMAX, VMAX, 1'b1, 1'b1}, 1'b0},
    '{'{ONE, -ONE, ONE, -ONE, ONE, -ONE, ONE, 1'b1, 1'b0}, 1'b1},
    '{'{16'sd0, 16'sd0, 16'sd0, VMIN, VMIN, VMIN, VMIN, 1'b0, 1'b1}, 1'b0},
    '{'{16'sd0, 16'sd0, 16'sd0, VMIN, VMIN, VMIN, VMIN, 1'b0, 1'b1}, 1'b0},
    '{'{16'sd0, 16'sd0, 16'sd0, VMIN, VMIN, VMIN, VMIN, 1'b0, 1'b1}, 1'b0},
    '{'{16'sd0, 16'sd0, 16'sd0, VMIN, VMIN, VMIN, VMIN, 1'b0, 1'b1}, 1'b0},
    '{'{16'sd0, 16'sd0, 16'sd0, VMAX, VMAX, VMAX, VMAX, 1'b0, 1'b1}, 1'b0},
    '{'{16'sd0, 16'sd0, 16'sd0, VMAX, VMAX, VMAX, VMAX, 1'b0, 1'b1}, 1'b0},
    '{'{16'sd0, 16'sd0, 16'sd0, VMAX, VMAX, VMAX, VMAX, 1'b0, 1'b1}, 1'b0},
    '{'{16'sd0, 16'sd0, ONE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1}, 1'b0},
    '{'{16'sd0, 16'sd0, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1}, 1'b0},
    '{'{16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1}, 1'b0},
    '{'{ONE, -ONE, 16'sd0, ONE, -ONE, ONE, -ONE, 1'b1, 1'b1}, 1'b0},
    '{'{16'sd14336, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1}, 1'b0},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1}, 1'b0}
  };

  mecanum_wheel_speed_controller_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_vel_x       (in_vel_x),
    .in_vel_y       (in_vel_y),
    .in_vel_z       (in_vel_z),
    .in_meas_a      (in_meas_a),
    .in_meas_b      (in_meas_b),
    .in_meas_c      (in_meas_c),
    .in_meas_d      (in_meas_d),
    .in_move_enable (in_move_enable),
    .in_power_ok    (in_power_ok),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cmp_a1     (out_cmp_a1),
    .out_cmp_a2     (out_cmp_a2),
    .out_cmp_b1     (out_cmp_b1),
    .out_cmp_b2     (out_cmp_b2),
    .out_cmp_c1     (out_cmp_c1),
    .out_cmp_c2     (out_cmp_c2),
    .out_cmp_d1     (out_cmp_d1),
    .out_cmp_d2     (out_cmp_d2)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint clamp_mag(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic cmp_pair_t h_bridge(input longint m);
    longint hi, lo;
    cmp_pair_t r;
    hi = (m < 0) ? longint'(PWM_TOP) : longint'(PWM_TOP) - m;
    lo = (m < 0) ? longint'(PWM_TOP) + m : longint'(PWM_TOP);
    if (hi < 0) hi = 0;
    if (lo < 0) lo = 0;
    r.first  = hi[CMP_W-1:0];
    r.second = lo[CMP_W-1:0];
    return r;
  endfunction

  // one control tick: kinematics, four PI loops, bridge split
  function automatic cmp_vec_t pi_tick(input tick_beat_t b);
    longint sat, rot, lim, err, acc, drv;
    longint tgt [4];
    longint meas [4];
    cmp_vec_t r;
    cmp_pair_t p;
    if (!b.pwr_ok) return {8{CMP_W'(PWM_TOP)}};
    sat = longint'(DRIVE_LIMIT) <<< FRAC_BITS;
    meas[0] = longint'(b.ma);
    meas[1] = longint'(b.mb);
    meas[2] = longint'(b.mc);
    meas[3] = longint'(b.md);
    tgt = '{default: 0};
    if (b.move_en) begin
      rot = (longint'(b.vz) * longint'(geom) + (longint'(1) <<< (GEOM_BITS - 1)))
            >>> GEOM_BITS;
      lim = longint'(vlim);
      tgt[0] = clamp_mag(longint'(b.vx) + longint'(b.vy) - rot, lim);
      tgt[1] = clamp_mag(longint'(b.vx) - longint'(b.vy) - rot, lim);
      tgt[2] = clamp_mag(longint'(b.vx) + longint'(b.vy) + rot, lim);
      tgt[3] = clamp_mag(longint'(b.vx) - longint'(b.vy) + rot, lim);
    end
    for (int i = 0; i < NWHEEL; i++) begin
      err = tgt[i] - meas[i];
      acc = clamp_mag(longint'(drive_acc[i])
                      + longint'(kp) * (err - longint'(prev_err[i]))
                      + longint'(ki[i]) * err, sat);
      drive_acc[i] = ACC_W'(acc);
      prev_err[i]  = ERR_W'(err);
      drv = acc / (longint'(1) <<< FRAC_BITS);
      p = h_bridge((i == 1 || i == 2) ? -drv : drv);
      r[2*i]   = p.first;
      r[2*i+1] = p.second;
    end
    return r;
  endfunction

  function automatic logic signed [VEL_W-1:0] rand_speed();
    case ($urandom_range(3))
      0: return VEL_W'($urandom);
      1: return $signed(VEL_W'($urandom_range(8191))) - 16'sd4096;
      default: return $signed(VEL_W'($urandom_range(32767))) - 16'sd16384;
    endcase
  endfunction

  function automatic tick_beat_t rand_tick();
    tick_beat_t b;
    b.vx = rand_speed();
    b.vy = rand_speed();
    b.vz = rand_speed();
    b.ma = rand_speed();
    b.mb = rand_speed();
    b.mc = rand_speed();
    b.md = rand_speed();
    b.move_en = ($urandom_range(99) < 85);
    b.pwr_ok  = ($urandom_range(99) < 90);
    return b;
  endfunction

  task automatic flag_bad(input string msg);
    if (bad_cnt < 10) $display("mismatch: %s", msg);
    bad_cnt++;
  endtask

  task automatic offer_tick(input tick_beat_t b, input logic at_top);
    cmp_vec_t w;
    if (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_valid       <= 1'b1;
    in_vel_x       <= b.vx;
    in_vel_y       <= b.vy;
    in_vel_z       <= b.vz;
    in_meas_a      <= b.ma;
    in_meas_b      <= b.mb;
    in_meas_c      <= b.mc;
    in_meas_d      <= b.md;
    in_move_enable <= b.move_en;
    in_power_ok    <= b.pwr_ok;
    do @(posedge clk); while (!in_ready);
    w = pi_tick(b);
    if (at_top) w = {8{CMP_W'(PWM_TOP)}};
    pending_cmp.push_back(w);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_cmp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic run_ticks(input int n);
    repeat (n) offer_tick(rand_tick(), 1'b0);
  endtask

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_PROP_GAIN:  kp    = val;
      REG_INT_GAIN_A: ki[0] = val;
      REG_INT_GAIN_B: ki[1] = val;
      REG_INT_GAIN_C: ki[2] = val;
      REG_INT_GAIN_D: ki[3] = val;
      REG_GEOMETRY:   geom  = val;
      REG_SPEED_LIM:  vlim  = val[LIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_load(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] a,
                          input logic [GAIN_W-1:0] b, input logic [GAIN_W-1:0] c,
                          input logic [GAIN_W-1:0] d, input logic [GAIN_W-1:0] g,
                          input logic [GAIN_W-1:0] lim);
    drain();
    cfg_write(REG_PROP_GAIN, p);
    cfg_write(REG_INT_GAIN_A, a);
    cfg_write(REG_INT_GAIN_B, b);
    cfg_write(REG_INT_GAIN_C, c);
    cfg_write(REG_INT_GAIN_D, d);
    cfg_write(REG_GEOMETRY, g);
    cfg_write(REG_SPEED_LIM, lim);
    cfg_write(REG_UNUSED, GAIN_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic cfg_random();
    cfg_load(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
             GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom));
  endtask

  // result side: stall pattern, long hold-off and beat checking
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        seen_cmp = {out_cmp_d2, out_cmp_d1, out_cmp_c2, out_cmp_c1,
                    out_cmp_b2, out_cmp_b1, out_cmp_a2, out_cmp_a1};
        if (pending_cmp.size() == 0) begin
          flag_bad("result beat with nothing pending");
        end else begin
          want_cmp = pending_cmp.pop_front();
          for (int k = 0; k < 8; k++)
            if (seen_cmp[k] !== want_cmp[k])
              flag_bad($sformatf("%s expected %0d got %0d",
                                 fld_name[k], want_cmp[k], seen_cmp[k]));
        end
      end
      if (hold_tog != hold_seen) begin
        hold_seen <= hold_tog;
        hold_left <= HOLD_LEN;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cyc <= 0;
    end else if (stuck_cyc >= STUCK_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stuck_cyc <= stuck_cyc + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < 20; k++) offer_tick(dir_rows[k].beat, dir_rows[k].at_top);

    cfg_random();
    run_ticks(70);

    // all gains, geometry and limit at zero
    cfg_load('0, '0, '0, '0, '0, '0, '0);
    snd_idle_pct = 80;
    run_ticks(40);

    cfg_load('1, '1, '1, '1, '1, '1, 16'h7fff);
    snd_idle_pct = 0;
    rcv_stall_pct <= 80;
    run_ticks(70);

    // receiver holds off while ticks keep coming, then sender waits for the pipe to empty
    cfg_load(KP_RST, KA_RST, KB_RST, KC_RST, KD_RST, GEOM_RST, VLIM_RST);
    rcv_stall_pct <= 0;
    hold_tog <= ~hold_tog;
    run_ticks(30);
    drain();
    run_ticks(30);

    cfg_random();
    snd_idle_pct = 17;
    rcv_stall_pct <= 17;
    run_ticks(80);

    cfg_random();
    snd_idle_pct = 0;
    rcv_stall_pct <= 0;
    run_ticks(80);

    cfg_load(KP_RST, KA_RST, KB_RST, KC_RST, KD_RST, GEOM_RST, VLIM_RST);
    snd_idle_pct = 80;
    run_ticks(50);

    drain();
    if (bad_cnt == 0 && pending_cmp.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
